[rtl/kcgu_pkg.sv]
// shared types, codes and saturation helper for the kalman covariance and gain update
`default_nettype none
package kcgu_pkg;

  localparam int unsigned IDX_W     = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DIV_STEPS = 48;
  localparam int unsigned DIV_CW    = 6;

  localparam logic signed [DATA_W-1:0] ONE_Q = 32'sd65536;

  localparam logic [2:0] OP_LOAD_P   = 3'd0;
  localparam logic [2:0] OP_LOAD_PHI = 3'd1;
  localparam logic [2:0] OP_LOAD_Q   = 3'd2;
  localparam logic [2:0] OP_LOAD_R   = 3'd3;
  localparam logic [2:0] OP_LOAD_H   = 3'd4;
  localparam logic [2:0] OP_RUN      = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  typedef struct packed {
    logic [2:0]               op;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                     which;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] out_value;
    logic [1:0]               status;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  function automatic sat_t sat32(logic signed [63:0] v);
    sat_t r;
    if (v > 64'sd2147483647) begin
      r.hit = 1'b1;
      r.val = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r.hit = 1'b1;
      r.val = 32'sh80000000;
    end else begin
      r.hit = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/kalman_covariance_gain_update_core.sv]
// kalman covariance and gain update core: matrix store, shared mac pipeline and sequencer
//
//  channel | direction | payload              | handshake
//  in      | input     | kcgu_pkg::in_item_t  | in_valid_i / in_ready_o
//  out     | output    | kcgu_pkg::out_item_t | out_valid_o / out_ready_i
//
// a load item is written to the store as it is accepted; a run item goes through the
// matrix steps on the one multiply pipeline and MEAS_DIM * 2*MEAS_DIM pivot divisions
// on the bit-serial divider.
// reset clears control only; the matrix store holds nothing valid until loaded.
// the input is not ready during a run; each result waits in the output register for ready.
`default_nettype none
module kalman_covariance_gain_update_core #(
  parameter int unsigned STATE_DIM = 4,
  parameter int unsigned MEAS_DIM  = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire kcgu_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output kcgu_pkg::out_item_t      out_data_o
);

  localparam int unsigned N2    = STATE_DIM * STATE_DIM;
  localparam int unsigned NP    = STATE_DIM * MEAS_DIM;
  localparam int unsigned PP    = MEAS_DIM * MEAS_DIM;
  localparam int unsigned P_B   = 0;
  localparam int unsigned PHI_B = N2;
  localparam int unsigned Q_B   = 2 * N2;
  localparam int unsigned M_B   = 3 * N2;
  localparam int unsigned T_B   = 4 * N2;
  localparam int unsigned D_B   = 5 * N2;
  localparam int unsigned R_B   = 6 * N2;
  localparam int unsigned H_B   = R_B + PP;
  localparam int unsigned HM_B  = H_B + NP;
  localparam int unsigned ST_B  = HM_B + NP;
  localparam int unsigned AUG_B = ST_B + PP;
  localparam int unsigned U_B   = AUG_B + 2 * PP;
  localparam int unsigned K_B   = U_B + NP;
  localparam int unsigned TOTAL = K_B + NP;
  localparam int unsigned AW    = $clog2(TOTAL);
  localparam int unsigned IW    = kcgu_pkg::IDX_W;

  localparam logic [AW-1:0] A0  = '0;
  localparam logic [AW-1:0] A1  = AW'(1);
  localparam logic [AW-1:0] AN  = AW'(STATE_DIM);
  localparam logic [AW-1:0] AP  = AW'(MEAS_DIM);
  localparam logic [AW-1:0] AW2 = AW'(2 * MEAS_DIM);

  localparam logic [IW-1:0] LN   = IW'(STATE_DIM - 1);
  localparam logic [IW-1:0] LP   = IW'(MEAS_DIM - 1);
  localparam logic [IW-1:0] LW2  = IW'(2 * MEAS_DIM - 1);
  localparam logic [IW-1:0] CNTP = IW'(MEAS_DIM);

  typedef enum logic [4:0] {
    S_IDLE, S_ENG, S_DRAIN, S_PV_RD, S_PV_CHK, S_SW_RD, S_SW_W1, S_SW_W2,
    S_PIV_RD, S_PIV_GET, S_NRM_RD, S_NRM_GO, S_NRM_WAIT, S_EL_SEL, S_EL_RD,
    S_EL_F, S_ERR, S_EM_RD, S_EM_LD, S_EM_WAIT
  } state_e;

  typedef enum logic [3:0] {
    P_PHIP, P_TPHI, P_ADDQ, P_HM, P_HMH, P_ADDR, P_IDENT, P_ELIM,
    P_U, P_KG, P_KH, P_ISUB, P_PNEW
  } step_e;

  typedef enum logic [2:0] {
    MD_MUL, MD_ADD, MD_ISUB, MD_IDENT, MD_ELIM
  } mode_e;

  typedef struct packed {
    mode_e         mode;
    logic [AW-1:0] ba, sai, saj, sak;
    logic [AW-1:0] bb, sbi, sbj, sbk;
    logic [AW-1:0] bc, sci;
    logic [IW-1:0] lr, lq, lm;
  } desc_t;

  typedef struct packed {
    logic          v;
    logic          first;
    logic          last;
    logic          diag;
    logic [AW-1:0] ca;
  } tag_t;

  function automatic logic [AW-1:0] ad(logic [AW-1:0] b, logic [IW-1:0] i, logic [AW-1:0] si,
                                       logic [IW-1:0] j, logic [AW-1:0] sj,
                                       logic [IW-1:0] k, logic [AW-1:0] sk);
    return b + AW'(i) * si + AW'(j) * sj + AW'(k) * sk;
  endfunction

  state_e state_q;
  step_e  step_q;
  desc_t  dsc;

  logic [IW-1:0] ei_q, ej_q, ek_q;
  logic [IW-1:0] ic_q, ir_q, ij_q, best_q;
  logic [32:0]   bmag_q;
  logic signed [31:0] piv_q, f_q, tmp_q;
  logic          sat_q;
  logic          ew_q;
  logic [IW-1:0] er_q, ec_q;
  logic          out_valid_q;
  kcgu_pkg::out_item_t out_q;

  // matrix store
  logic signed [31:0] mem [TOTAL];
  logic [AW-1:0]      ra, rb, wa;
  logic               we;
  logic signed [31:0] wd;
  logic signed [31:0] rd_a_q, rd_b_q;

  // mac pipeline
  tag_t               t1_q, t2_q, t3_q;
  logic signed [63:0] prod_q;
  logic signed [47:0] term_q;
  logic signed [50:0] acc_q, acc_d;
  logic signed [31:0] a2_q, b2_q, a3_q, b3_q;
  logic               eng_we;
  kcgu_pkg::sat_t     eng_res, tsat;

  logic           div_start, div_done;
  kcgu_pkg::sat_t div_q;

  logic          in_acc;
  logic          ld_ok;
  logic [AW-1:0] ld_addr;
  logic [32:0]   mag;
  logic          take;
  logic [32:0]   nbmag;
  logic [IW-1:0] nbest;
  logic          em_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // operand layout of each step
  always_comb begin
    dsc = '{mode: MD_MUL, ba: A0, sai: A0, saj: A0, sak: A0, bb: A0, sbi: A0, sbj: A0,
            sbk: A0, bc: A0, sci: A0, lr: LN, lq: LN, lm: LN};
    unique case (step_q)
      P_PHIP: dsc = '{MD_MUL, AW'(PHI_B), AN, A0, A1, AW'(P_B), A0, A1, AN,
                      AW'(T_B), AN, LN, LN, LN};
      P_TPHI: dsc = '{MD_MUL, AW'(T_B), AN, A0, A1, AW'(PHI_B), A0, AN, A1,
                      AW'(D_B), AN, LN, LN, LN};
      P_ADDQ: dsc = '{MD_ADD, AW'(D_B), AN, A1, A0, AW'(Q_B), AN, A1, A0,
                      AW'(M_B), AN, LN, LN, '0};
      P_HM:   dsc = '{MD_MUL, AW'(H_B), AN, A0, A1, AW'(M_B), A0, A1, AN,
                      AW'(HM_B), AN, LP, LN, LN};
      P_HMH:  dsc = '{MD_MUL, AW'(HM_B), AN, A0, A1, AW'(H_B), A0, AN, A1,
                      AW'(ST_B), AP, LP, LP, LN};
      P_ADDR: dsc = '{MD_ADD, AW'(ST_B), AP, A1, A0, AW'(R_B), AP, A1, A0,
                      AW'(AUG_B), AW2, LP, LP, '0};
      P_IDENT: dsc = '{MD_IDENT, A0, A0, A0, A0, A0, A0, A0, A0,
                       AW'(AUG_B + MEAS_DIM), AW2, LP, LP, '0};
      P_ELIM: dsc = '{MD_ELIM, AW'(AUG_B) + AW'(ir_q) * AW2, A0, A1, A0,
                      AW'(AUG_B) + AW'(ic_q) * AW2, A0, A1, A0,
                      AW'(AUG_B) + AW'(ir_q) * AW2, A0, '0, LW2, '0};
      P_U:    dsc = '{MD_MUL, AW'(M_B), AN, A0, A1, AW'(H_B), A0, AN, A1,
                      AW'(U_B), AP, LN, LP, LN};
      P_KG:   dsc = '{MD_MUL, AW'(U_B), AP, A0, A1, AW'(AUG_B + MEAS_DIM), A0, A1, AW2,
                      AW'(K_B), AP, LN, LP, LP};
      P_KH:   dsc = '{MD_MUL, AW'(K_B), AP, A0, A1, AW'(H_B), A0, A1, AN,
                      AW'(T_B), AN, LN, LN, LP};
      P_ISUB: dsc = '{MD_ISUB, AW'(T_B), AN, A1, A0, A0, A0, A0, A0,
                      AW'(D_B), AN, LN, LN, '0};
      P_PNEW: dsc = '{MD_MUL, AW'(D_B), AN, A0, A1, AW'(M_B), A0, A1, AN,
                      AW'(P_B), AN, LN, LN, LN};
      default: ;
    endcase
  end

  // load decode
  always_comb begin
    ld_ok   = 1'b0;
    ld_addr = A0;
    unique case (in_data_i.op)
      kcgu_pkg::OP_LOAD_P: begin
        ld_ok   = (in_data_i.row <= LN) && (in_data_i.col <= LN);
        ld_addr = ad(AW'(P_B), in_data_i.row, AN, in_data_i.col, A1, '0, A0);
      end
      kcgu_pkg::OP_LOAD_PHI: begin
        ld_ok   = (in_data_i.row <= LN) && (in_data_i.col <= LN);
        ld_addr = ad(AW'(PHI_B), in_data_i.row, AN, in_data_i.col, A1, '0, A0);
      end
      kcgu_pkg::OP_LOAD_Q: begin
        ld_ok   = (in_data_i.row <= LN) && (in_data_i.col <= LN);
        ld_addr = ad(AW'(Q_B), in_data_i.row, AN, in_data_i.col, A1, '0, A0);
      end
      kcgu_pkg::OP_LOAD_R: begin
        ld_ok   = (in_data_i.row <= LP) && (in_data_i.col <= LP);
        ld_addr = ad(AW'(R_B), in_data_i.row, AP, in_data_i.col, A1, '0, A0);
      end
      kcgu_pkg::OP_LOAD_H: begin
        ld_ok   = (in_data_i.row <= LP) && (in_data_i.col <= LN);
        ld_addr = ad(AW'(H_B), in_data_i.row, AN, in_data_i.col, A1, '0, A0);
      end
      default: ;
    endcase
  end

  // read address selection
  always_comb begin
    ra = A0;
    rb = A0;
    unique case (state_q)
      S_ENG: begin
        ra = ad(dsc.ba, ei_q, dsc.sai, ej_q, dsc.saj, ek_q, dsc.sak);
        rb = ad(dsc.bb, ei_q, dsc.sbi, ej_q, dsc.sbj, ek_q, dsc.sbk);
      end
      S_PV_RD:  ra = ad(AW'(AUG_B), ir_q, AW2, ic_q, A1, '0, A0);
      S_SW_RD: begin
        ra = ad(AW'(AUG_B), ic_q, AW2, ij_q, A1, '0, A0);
        rb = ad(AW'(AUG_B), best_q, AW2, ij_q, A1, '0, A0);
      end
      S_PIV_RD: ra = ad(AW'(AUG_B), ic_q, AW2, ic_q, A1, '0, A0);
      S_NRM_RD: ra = ad(AW'(AUG_B), ic_q, AW2, ij_q, A1, '0, A0);
      S_EL_RD:  ra = ad(AW'(AUG_B), ir_q, AW2, ic_q, A1, '0, A0);
      S_EM_RD:  ra = ew_q ? ad(AW'(P_B), er_q, AN, ec_q, A1, '0, A0)
                          : ad(AW'(K_B), er_q, AP, ec_q, A1, '0, A0);
      default: ;
    endcase
  end

  // last stage of the mac pipeline
  always_comb begin
    acc_d   = (t3_q.first ? 51'sd0 : acc_q) + 51'(term_q);
    tsat    = kcgu_pkg::sat32(64'(term_q));
    eng_res = '0;
    unique case (dsc.mode)
      MD_MUL:   eng_res = kcgu_pkg::sat32(64'(acc_d));
      MD_ADD:   eng_res = kcgu_pkg::sat32(64'(a3_q) + 64'(b3_q));
      MD_ISUB:  eng_res = kcgu_pkg::sat32((t3_q.diag ? 64'(kcgu_pkg::ONE_Q) : 64'sd0)
                                          - 64'(a3_q));
      MD_IDENT: eng_res = '{1'b0, t3_q.diag ? kcgu_pkg::ONE_Q : 32'sd0};
      MD_ELIM: begin
        eng_res = kcgu_pkg::sat32(64'(a3_q) - 64'(tsat.val));
        eng_res.hit = eng_res.hit | tsat.hit;
      end
      default: ;
    endcase
    eng_we = t3_q.v && t3_q.last;
  end

  // write port selection
  always_comb begin
    we = 1'b0;
    wa = A0;
    wd = '0;
    if (eng_we) begin
      we = 1'b1;
      wa = t3_q.ca;
      wd = eng_res.val;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          we = in_acc && ld_ok;
          wa = ld_addr;
          wd = in_data_i.value;
        end
        S_SW_W1: begin
          we = 1'b1;
          wa = ad(AW'(AUG_B), ic_q, AW2, ij_q, A1, '0, A0);
          wd = rd_b_q;
        end
        S_SW_W2: begin
          we = 1'b1;
          wa = ad(AW'(AUG_B), best_q, AW2, ij_q, A1, '0, A0);
          wd = tmp_q;
        end
        S_NRM_WAIT: begin
          we = div_done;
          wa = ad(AW'(AUG_B), ic_q, AW2, ij_q, A1, '0, A0);
          wd = div_q.val;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
    end else begin
      t1_q.v     <= (state_q == S_ENG);
      t1_q.first <= (ek_q == '0);
      t1_q.last  <= (ek_q == dsc.lm);
      t1_q.diag  <= (ei_q == ej_q);
      t1_q.ca    <= ad(dsc.bc, ei_q, dsc.sci, ej_q, A1, '0, A0);
      t2_q       <= t1_q;
      t3_q       <= t2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ((dsc.mode == MD_ELIM) ? f_q : rd_a_q) * rd_b_q;
    a2_q   <= rd_a_q;
    b2_q   <= rd_b_q;
    // round half up to q16.16
    term_q <= 48'((prod_q + 64'sd32768) >>> kcgu_pkg::FRAC_W);
    a3_q   <= a2_q;
    b3_q   <= b2_q;
    if (t3_q.v) begin
      acc_q <= acc_d;
    end
  end

  kcgu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (rd_a_q),
    .den_i   (piv_q),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  assign div_start = (state_q == S_NRM_GO);

  // pivot search, first row wins ties
  assign mag   = rd_a_q[31] ? (33'd0 - {1'b1, rd_a_q}) : {1'b0, rd_a_q};
  assign take  = (ir_q == ic_q) || (mag > bmag_q);
  assign nbmag = take ? mag : bmag_q;
  assign nbest = take ? ir_q : best_q;

  assign em_last = ew_q && (er_q == LN) && (ec_q == LN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= P_PHIP;
      ei_q        <= '0;
      ej_q        <= '0;
      ek_q        <= '0;
      ic_q        <= '0;
      ir_q        <= '0;
      ij_q        <= '0;
      best_q      <= '0;
      bmag_q      <= '0;
      piv_q       <= '0;
      f_q         <= '0;
      tmp_q       <= '0;
      sat_q       <= 1'b0;
      ew_q        <= 1'b0;
      er_q        <= '0;
      ec_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (eng_we && eng_res.hit) begin
        sat_q <= 1'b1;
      end
      if (div_done && div_q.hit) begin
        sat_q <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && (in_data_i.op == kcgu_pkg::OP_RUN)) begin
            sat_q   <= 1'b0;
            step_q  <= P_PHIP;
            ei_q    <= '0;
            ej_q    <= '0;
            ek_q    <= '0;
            state_q <= S_ENG;
          end
        end
        S_ENG: begin
          if (ek_q == dsc.lm) begin
            ek_q <= '0;
            if (ej_q == dsc.lq) begin
              ej_q <= '0;
              if (ei_q == dsc.lr) begin
                ei_q    <= '0;
                state_q <= S_DRAIN;
              end else begin
                ei_q <= ei_q + 1'b1;
              end
            end else begin
              ej_q <= ej_q + 1'b1;
            end
          end else begin
            ek_q <= ek_q + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!t1_q.v && !t2_q.v && !t3_q.v) begin
            priority case (step_q)
              P_IDENT: begin
                ic_q    <= '0;
                ir_q    <= '0;
                state_q <= S_PV_RD;
              end
              P_ELIM: begin
                ir_q    <= ir_q + 1'b1;
                state_q <= S_EL_SEL;
              end
              P_PNEW: begin
                ew_q    <= 1'b0;
                er_q    <= '0;
                ec_q    <= '0;
                state_q <= S_EM_RD;
              end
              default: begin
                step_q  <= step_e'(step_q + 1'b1);
                state_q <= S_ENG;
              end
            endcase
          end
        end
        S_PV_RD: state_q <= S_PV_CHK;
        S_PV_CHK: begin
          bmag_q <= nbmag;
          best_q <= nbest;
          if (ir_q == LP) begin
            if (nbmag == '0) begin
              state_q <= S_ERR;
            end else if (nbest != ic_q) begin
              ij_q    <= '0;
              state_q <= S_SW_RD;
            end else begin
              state_q <= S_PIV_RD;
            end
          end else begin
            ir_q    <= ir_q + 1'b1;
            state_q <= S_PV_RD;
          end
        end
        S_SW_RD: state_q <= S_SW_W1;
        S_SW_W1: begin
          tmp_q   <= rd_a_q;
          state_q <= S_SW_W2;
        end
        S_SW_W2: begin
          if (ij_q == LW2) begin
            state_q <= S_PIV_RD;
          end else begin
            ij_q    <= ij_q + 1'b1;
            state_q <= S_SW_RD;
          end
        end
        S_PIV_RD: state_q <= S_PIV_GET;
        S_PIV_GET: begin
          piv_q   <= rd_a_q;
          ij_q    <= '0;
          state_q <= S_NRM_RD;
        end
        S_NRM_RD: state_q <= S_NRM_GO;
        S_NRM_GO: state_q <= S_NRM_WAIT;
        S_NRM_WAIT: begin
          if (div_done) begin
            if (ij_q == LW2) begin
              ir_q    <= '0;
              state_q <= S_EL_SEL;
            end else begin
              ij_q    <= ij_q + 1'b1;
              state_q <= S_NRM_RD;
            end
          end
        end
        S_EL_SEL: begin
          if (ir_q == CNTP) begin
            if (ic_q == LP) begin
              step_q  <= P_U;
              state_q <= S_ENG;
            end else begin
              ic_q    <= ic_q + 1'b1;
              ir_q    <= ic_q + 1'b1;
              state_q <= S_PV_RD;
            end
          end else if (ir_q == ic_q) begin
            ir_q <= ir_q + 1'b1;
          end else begin
            state_q <= S_EL_RD;
          end
        end
        S_EL_RD: state_q <= S_EL_F;
        S_EL_F: begin
          f_q     <= rd_a_q;
          step_q  <= P_ELIM;
          state_q <= S_ENG;
        end
        S_ERR: begin
          out_q       <= '{1'b0, '0, '0, 32'sd0, kcgu_pkg::ST_SINGULAR, 1'b1};
          out_valid_q <= 1'b1;
          state_q     <= S_EM_WAIT;
        end
        S_EM_RD: state_q <= S_EM_LD;
        S_EM_LD: begin
          out_q       <= '{ew_q, er_q, ec_q, rd_a_q,
                           sat_q ? kcgu_pkg::ST_SAT : kcgu_pkg::ST_OK, em_last};
          out_valid_q <= 1'b1;
          state_q     <= S_EM_WAIT;
        end
        S_EM_WAIT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (out_q.last) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= S_EM_RD;
              if (ec_q == (ew_q ? LN : LP)) begin
                ec_q <= '0;
                if (er_q == LN) begin
                  er_q <= '0;
                  ew_q <= 1'b1;
                end else begin
                  er_q <= er_q + 1'b1;
                end
              end else begin
                ec_q <= ec_q + 1'b1;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.last) |=> in_ready_o)
    else $error("block not idle after the final result of a run");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PV_RD || state_q == S_EM_RD) |-> (!t1_q.v && !t2_q.v && !t3_q.v))
    else $error("mac pipeline still busy when the sequencer reads the store");

  a_eng_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t3_q.v |-> (state_q == S_ENG || state_q == S_DRAIN))
    else $error("mac write outside a matrix step");

endmodule
`default_nettype wire

[rtl/kcgu_div.sv]
// iterative signed q16.16 divider, one quotient bit per cycle, saturating
`default_nettype none
module kcgu_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [31:0]       num_i,
  input  wire logic signed [31:0]       den_i,
  output logic                          done_o,
  output kcgu_pkg::sat_t                quot_o
);

  localparam int unsigned QW = kcgu_pkg::DIV_STEPS;

  logic                 busy_q;
  logic                 done_q;
  logic                 neg_q;
  logic [kcgu_pkg::DIV_CW-1:0] cnt_q;
  logic [31:0]          rem_q;
  logic [31:0]          den_q;
  logic [QW-1:0]        dvd_q;
  logic [QW-1:0]        quo_q;

  logic [31:0] num_mag, den_mag;
  logic [32:0] rem_n;
  logic        ge;

  assign num_mag = num_i[31] ? (~num_i + 32'd1) : num_i;
  assign den_mag = den_i[31] ? (~den_i + 32'd1) : den_i;
  assign rem_n   = {rem_q, dvd_q[QW-1]};
  assign ge      = rem_n >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      dvd_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        den_q  <= den_mag;
        neg_q  <= num_i[31] ^ den_i[31];
        dvd_q  <= {num_mag, {kcgu_pkg::FRAC_W{1'b0}}};
        quo_q  <= '0;
      end else if (busy_q) begin
        rem_q <= ge ? 32'(rem_n - {1'b0, den_q}) : rem_n[31:0];
        dvd_q <= {dvd_q[QW-2:0], 1'b0};
        quo_q <= {quo_q[QW-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == kcgu_pkg::DIV_CW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // truncation toward zero: divide magnitudes, then restore the sign
  always_comb begin
    quot_o.hit = 1'b0;
    quot_o.val = '0;
    if (neg_q) begin
      if (quo_q > QW'(64'd2147483648)) begin
        quot_o.hit = 1'b1;
        quot_o.val = 32'sh80000000;
      end else begin
        quot_o.val = ~quo_q[31:0] + 32'd1;
      end
    end else begin
      if (quo_q > QW'(64'd2147483647)) begin
        quot_o.hit = 1'b1;
        quot_o.val = 32'sh7fffffff;
      end else begin
        quot_o.val = quo_q[31:0];
      end
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

[tb/kalman_covariance_gain_update_core_tb.sv]
// testbench for the kalman covariance and gain update core: random loads and runs, checked by a predictor
`default_nettype none
module kalman_covariance_gain_update_core_tb;

  localparam int N = 4;
  localparam int P = 2;
  localparam int LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  kcgu_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  kcgu_pkg::out_item_t out_data_o;

  kalman_covariance_gain_update_core #(.STATE_DIM(N), .MEAS_DIM(P)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  // predictor state
  logic signed [31:0] cov_m [N*N];
  logic signed [31:0] phi_m [N*N];
  logic signed [31:0] q_m [N*N];
  logic signed [31:0] r_m [P*P];
  logic signed [31:0] h_m [P*N];
  bit sat_flag;

  kcgu_pkg::in_item_t pending_items[$];
  kcgu_pkg::out_item_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int runs_done = 0;
  int singular_runs = 0;
  int sat_runs = 0;
  int results_seen = 0;
  bit stim_done = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("kalman_covariance_gain_update_core_tb: FAIL");
      $finish;
    end
  end

  function automatic logic signed [31:0] clip(logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat_flag = 1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat_flag = 1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // rounded q16.16 product term, exact in 64 bits
  function automatic logic signed [63:0] prod_term(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    logic signed [63:0] x;
    x = 64'(a) * 64'(b) + 64'sd32768;
    return x >>> 16;
  endfunction

  function automatic logic signed [31:0] qdiv(logic signed [31:0] a,
                                              logic signed [31:0] b);
    logic signed [63:0] num;
    num = 64'(a) * 64'sd65536;
    return clip(num / 64'(b));
  endfunction

  // generic product c = a(r x m) * b or b' , flattened row-major
  function automatic void matmul(input logic signed [31:0] a[], input logic signed [31:0] b[],
                                 output logic signed [31:0] c[], input int r, input int m,
                                 input int q, input bit bt);
    logic signed [63:0] acc;
    logic signed [31:0] bv;
    c = new[r*q];
    for (int i = 0; i < r; i++)
      for (int j = 0; j < q; j++) begin
        acc = 0;
        for (int k = 0; k < m; k++) begin
          bv = bt ? b[j*m+k] : b[k*q+j];
          acc += prod_term(a[i*m+k], bv);
        end
        c[i*q+j] = clip(acc);
      end
  endfunction

  function automatic void add_item(bit which, int row, int col, logic signed [31:0] v,
                                   logic [1:0] st, bit lst);
    kcgu_pkg::out_item_t o;
    o.which = which;
    o.out_row = row[2:0];
    o.out_col = col[2:0];
    o.out_value = v;
    o.status = st;
    o.last = lst;
    expected_results.push_back(o);
  endfunction

  function automatic void predict_update();
    logic signed [31:0] cv[], ph[], qn[], rn[], hh[];
    logic signed [31:0] t[], m[], hm[], s[], si[], u[], k[], d[], pn[];
    logic signed [31:0] tmp, piv, f;
    logic signed [63:0] mag, bmag;
    int best, cnt;
    logic [1:0] st;
    cv = new[N*N]; ph = new[N*N]; qn = new[N*N]; rn = new[P*P]; hh = new[P*N];
    foreach (cv[i]) begin
      cv[i] = cov_m[i]; ph[i] = phi_m[i]; qn[i] = q_m[i];
    end
    foreach (rn[i]) rn[i] = r_m[i];
    foreach (hh[i]) hh[i] = h_m[i];
    sat_flag = 0;
    runs_done++;
    matmul(ph, cv, t, N, N, N, 1'b0);
    matmul(t, ph, m, N, N, N, 1'b1);
    for (int i = 0; i < N*N; i++) m[i] = clip(64'(m[i]) + 64'(qn[i]));
    matmul(hh, m, hm, P, N, N, 1'b0);
    matmul(hm, hh, s, P, N, P, 1'b1);
    for (int i = 0; i < P*P; i++) s[i] = clip(64'(s[i]) + 64'(rn[i]));
    si = new[P*P];
    for (int i = 0; i < P*P; i++) si[i] = (i / P == i % P) ? kcgu_pkg::ONE_Q : 32'sd0;
    for (int c = 0; c < P; c++) begin
      best = c;
      bmag = -1;
      for (int r = c; r < P; r++) begin
        mag = 64'(s[r*P+c]);
        if (mag < 0) mag = -mag;
        if (mag > bmag) begin
          bmag = mag;
          best = r;
        end
      end
      if (bmag == 0) begin
        singular_runs++;
        add_item(1'b0, 0, 0, 32'sd0, kcgu_pkg::ST_SINGULAR, 1'b1);
        return;
      end
      if (best != c)
        for (int j = 0; j < P; j++) begin
          tmp = s[c*P+j]; s[c*P+j] = s[best*P+j]; s[best*P+j] = tmp;
          tmp = si[c*P+j]; si[c*P+j] = si[best*P+j]; si[best*P+j] = tmp;
        end
      piv = s[c*P+c];
      for (int j = 0; j < P; j++) begin
        s[c*P+j] = qdiv(s[c*P+j], piv);
        si[c*P+j] = qdiv(si[c*P+j], piv);
      end
      for (int r = 0; r < P; r++) begin
        if (r == c) continue;
        f = s[r*P+c];
        for (int j = 0; j < P; j++) begin
          s[r*P+j] = clip(64'(s[r*P+j]) - 64'(clip(prod_term(f, s[c*P+j]))));
          si[r*P+j] = clip(64'(si[r*P+j]) - 64'(clip(prod_term(f, si[c*P+j]))));
        end
      end
    end
    matmul(m, hh, u, N, N, P, 1'b1);
    matmul(u, si, k, N, P, P, 1'b0);
    matmul(k, hh, t, N, P, N, 1'b0);
    d = new[N*N];
    for (int i = 0; i < N*N; i++)
      d[i] = clip(((i / N == i % N) ? 64'sd65536 : 64'sd0) - 64'(t[i]));
    matmul(d, m, pn, N, N, N, 1'b0);
    for (int i = 0; i < N*N; i++) cov_m[i] = pn[i];
    st = sat_flag ? kcgu_pkg::ST_SAT : kcgu_pkg::ST_OK;
    if (sat_flag) sat_runs++;
    cnt = 0;
    for (int i = 0; i < N*P; i++, cnt++)
      add_item(1'b0, i / P, i % P, k[i], st, cnt == N*P + N*N - 1);
    for (int i = 0; i < N*N; i++, cnt++)
      add_item(1'b1, i / N, i % N, pn[i], st, cnt == N*P + N*N - 1);
  endfunction

  function automatic void predict(kcgu_pkg::in_item_t it);
    int r, c;
    r = it.row;
    c = it.col;
    case (it.op)
      kcgu_pkg::OP_LOAD_P:   if (r < N && c < N) cov_m[r*N+c] = it.value;
      kcgu_pkg::OP_LOAD_PHI: if (r < N && c < N) phi_m[r*N+c] = it.value;
      kcgu_pkg::OP_LOAD_Q:   if (r < N && c < N) q_m[r*N+c] = it.value;
      kcgu_pkg::OP_LOAD_R:   if (r < P && c < P) r_m[r*P+c] = it.value;
      kcgu_pkg::OP_LOAD_H:   if (r < P && c < N) h_m[r*N+c] = it.value;
      kcgu_pkg::OP_RUN:      predict_update();
      default:     ;
    endcase
  endfunction

  function automatic int short_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // input handshake as seen at the rising edge
  bit in_taken = 1'b0;
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
  end

  // driver
  int in_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        predict(in_data_i);
        if (in_gap == 0 && pending_items.size() > 0) begin
          in_data_i <= pending_items.pop_front();
          in_gap = short_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (in_gap > 0) in_gap--;
        else if (pending_items.size() > 0) begin
          in_data_i <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          in_gap = short_gap();
        end
      end
      out_ready_i <= (short_gap() == 0);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    kcgu_pkg::out_item_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, out_data_o);
      end else begin
        e = expected_results.pop_front();
        if (out_data_o.which !== e.which || out_data_o.out_row !== e.out_row ||
            out_data_o.out_col !== e.out_col || out_data_o.out_value !== e.out_value ||
            out_data_o.status !== e.status || out_data_o.last !== e.last) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, e, out_data_o);
        end
      end
    end
  end

  function automatic kcgu_pkg::in_item_t mk(logic [2:0] op, int r, int c,
                                            logic signed [31:0] v);
    kcgu_pkg::in_item_t it;
    it.op = op;
    it.row = r[2:0];
    it.col = c[2:0];
    it.value = v;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_val(int kind);
    case (kind)
      0: return $signed($urandom_range(0, 131072)) - 32'sd65536;
      1: return $signed($urandom_range(0, 16384)) - 32'sd8192;
      2: return $urandom();
      default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  // full well-formed set of all matrices with mostly modest values
  task automatic load_all(int kind_mix);
    int kd;
    for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++) begin
        kd = ($urandom_range(0, 19) < kind_mix) ? $urandom_range(2, 3) : $urandom_range(0, 1);
        pending_items.push_back(mk(kcgu_pkg::OP_LOAD_P, i, j, rand_val(kd)));
        pending_items.push_back(mk(kcgu_pkg::OP_LOAD_PHI, i, j, rand_val(kd)));
        pending_items.push_back(mk(kcgu_pkg::OP_LOAD_Q, i, j, rand_val(kd)));
      end
    for (int i = 0; i < P; i++)
      for (int j = 0; j < P; j++)
        pending_items.push_back(mk(kcgu_pkg::OP_LOAD_R, i, j,
                                   rand_val($urandom_range(0, 1))));
    for (int i = 0; i < P; i++)
      for (int j = 0; j < N; j++)
        pending_items.push_back(mk(kcgu_pkg::OP_LOAD_H, i, j,
                                   rand_val($urandom_range(0, 1))));
  endtask

  initial begin
    logic [2:0] op;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: identity-like setup, then singular, then a regular run, ignored items and a saturating run
    for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++) begin
        pending_items.push_back(mk(kcgu_pkg::OP_LOAD_P, i, j,
                                   i == j ? kcgu_pkg::ONE_Q : 32'sd0));
        pending_items.push_back(mk(kcgu_pkg::OP_LOAD_PHI, i, j,
                                   i == j ? kcgu_pkg::ONE_Q : 32'sd0));
        pending_items.push_back(mk(kcgu_pkg::OP_LOAD_Q, i, j, 32'sd0));
      end
    for (int i = 0; i < P; i++)
      for (int j = 0; j < P; j++) pending_items.push_back(mk(kcgu_pkg::OP_LOAD_R, i, j, 32'sd0));
    for (int i = 0; i < P; i++)
      for (int j = 0; j < N; j++) pending_items.push_back(mk(kcgu_pkg::OP_LOAD_H, i, j, 32'sd0));
    pending_items.push_back(mk(kcgu_pkg::OP_RUN, 0, 0, 32'sd0));          // singular innovation
    pending_items.push_back(mk(kcgu_pkg::OP_LOAD_H, 0, 0, kcgu_pkg::ONE_Q));
    pending_items.push_back(mk(kcgu_pkg::OP_LOAD_H, 1, 1, kcgu_pkg::ONE_Q));
    pending_items.push_back(mk(kcgu_pkg::OP_LOAD_R, 0, 0, kcgu_pkg::ONE_Q));
    pending_items.push_back(mk(kcgu_pkg::OP_LOAD_R, 1, 1, kcgu_pkg::ONE_Q));
    pending_items.push_back(mk(kcgu_pkg::OP_RUN, 7, 7, 32'shffffffff));
    pending_items.push_back(mk(kcgu_pkg::OP_LOAD_P, 7, 0, 32'sh7fffffff));  // ignored index
    pending_items.push_back(mk(kcgu_pkg::OP_LOAD_H, 2, 0, 32'sh7fffffff));  // ignored index
    pending_items.push_back(mk(3'd6, 5, 5, 32'sh80000000));        // unknown op
    pending_items.push_back(mk(3'd7, 0, 7, 32'sh7fffffff));
    pending_items.push_back(mk(kcgu_pkg::OP_LOAD_PHI, 0, 0, 32'sh7fffffff)); // saturating run
    pending_items.push_back(mk(kcgu_pkg::OP_LOAD_Q, 3, 3, 32'sh80000000));
    pending_items.push_back(mk(kcgu_pkg::OP_RUN, 0, 0, 32'sd0));

    // random: runs, some after a complete set, with sparse loads and noise between
    while (pending_items.size() < 400 && runs_done >= 0) begin
      if ($urandom_range(0, 3) == 0) load_all($urandom_range(0, 6));
      repeat ($urandom_range(0, 6)) begin
        op = 3'($urandom_range(0, 7));
        if (op == kcgu_pkg::OP_RUN) op = kcgu_pkg::OP_LOAD_Q;
        pending_items.push_back(mk(op, $urandom_range(0, 7), $urandom_range(0, 7),
                                   rand_val($urandom_range(0, 3))));
      end
      pending_items.push_back(mk(kcgu_pkg::OP_RUN, $urandom_range(0, 7), $urandom_range(0, 7),
                                 $urandom()));
    end
    while (pending_items.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
    $display("covered %0d update runs (%0d singular, %0d saturating), %0d results checked",
             runs_done, singular_runs, sat_runs, results_seen);
    if (errors == 0) begin
      $display("kalman_covariance_gain_update_core_tb: PASS");
    end else begin
      $display("kalman_covariance_gain_update_core_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
